// ----- design/tia_pkg.sv -----
// Shared types, opcodes and mask helper for the typed integer ALU.
// No dependencies; every other design file imports this package.
package tia_pkg;

    localparam int unsigned WordW = 64;

    typedef enum logic [4:0] {
        OP_NEG  = 5'd0,  OP_BNOT = 5'd1,  OP_LNOT = 5'd2,  OP_ADD  = 5'd3,
        OP_SUB  = 5'd4,  OP_MUL  = 5'd5,  OP_AND  = 5'd6,  OP_OR   = 5'd7,
        OP_XOR  = 5'd8,  OP_SHL  = 5'd9,  OP_USHR = 5'd10, OP_SHR  = 5'd11,
        OP_SDIV = 5'd12, OP_UDIV = 5'd13, OP_SMOD = 5'd14, OP_UMOD = 5'd15,
        OP_EQ   = 5'd16, OP_NE   = 5'd17, OP_LT   = 5'd18, OP_LE   = 5'd19,
        OP_GT   = 5'd20, OP_GE   = 5'd21, OP_ULT  = 5'd22, OP_ULE  = 5'd23,
        OP_UGT  = 5'd24, OP_UGE  = 5'd25, OP_ZEXT = 5'd26, OP_CONV = 5'd27
    } op_t;

    // Side information that rides along the chain with every word.
    typedef struct packed {
        logic [WordW-1:0] value;
        logic             ok;
        logic             norm;
        logic             is_div;
        logic             sel_rem;
        logic             neg;
        logic [6:0]       width;
        logic             uns;
    } tia_ctrl_t;

    // What one divider cell hands to the next.
    typedef struct packed {
        tia_ctrl_t        ctrl;
        logic [WordW-1:0] rem;
        logic [WordW-1:0] dq;
        logic [WordW-1:0] divisor;
    } tia_cell_t;

    // Mask of w low bits, with w clamped to the data width dw.
    function automatic logic [WordW-1:0] mask_of(input logic [6:0] w, input logic [6:0] dw);
        logic [6:0] c;
        c = (w > dw) ? dw : w;
        if (c >= 7'(WordW)) begin
            mask_of = '1;
        end else begin
            mask_of = (64'd1 << c[5:0]) - 64'd1;
        end
    endfunction

endpackage

// ----- design/tia_front.sv -----
// Input stage of the typed integer ALU: decodes the opcode, evaluates the
// non-divide operations, prepares divider operands and multiplier partials.
// Depends on tia_pkg.
module tia_front #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [4:0]             req_type,
    input  logic [63:0]            operand_a,
    input  logic [63:0]            operand_b,
    input  logic [6:0]             type_width,
    input  logic                   type_unsigned,
    input  logic [6:0]             zext_width,
    output logic                   out_valid,
    output tia_pkg::tia_cell_t     out_cell
);
    import tia_pkg::*;

    localparam logic [6:0] Dw = 7'(DATA_WIDTH);

    logic       valid_reg, valid_next;
    tia_cell_t  cell_reg, cell_next;
    logic       is_mul_reg, is_mul_next;
    logic [63:0] pp_ll_reg, pp_ll_next, pp_lh_reg, pp_lh_next, pp_hl_reg, pp_hl_next;

    logic [63:0] m, ua, ub, mag_a, mag_b, v;
    logic        ok, norm, shift_ok, div_ok, sgn;
    op_t         op;

    // Decode and evaluate every operation but the divides and the multiply.
    always_comb begin
        op       = op_t'(req_type);
        m        = mask_of(type_width, Dw);
        ua       = operand_a & m;
        ub       = operand_b & m;
        mag_a    = operand_a[63] ? (64'd0 - operand_a) : operand_a;
        mag_b    = operand_b[63] ? (64'd0 - operand_b) : operand_b;
        shift_ok = (operand_b[63:6] == '0);
        sgn      = (op == OP_SDIV) || (op == OP_SMOD);
        div_ok   = (operand_b != '0) &&
                   !(sgn && operand_a == 64'h8000_0000_0000_0000 && operand_b == '1);
        v        = '0;
        ok       = 1'b1;
        norm     = 1'b1;
        case (op)
            OP_NEG:  v = 64'd0 - operand_a;
            OP_BNOT: v = ~operand_a;
            OP_LNOT: begin v = {63'd0, operand_a == '0}; norm = 1'b0; end
            OP_ADD:  v = operand_a + operand_b;
            OP_SUB:  v = operand_a - operand_b;
            OP_MUL:  v = '0;
            OP_AND:  v = operand_a & operand_b;
            OP_OR:   v = operand_a | operand_b;
            OP_XOR:  v = operand_a ^ operand_b;
            OP_SHL:  begin v = operand_a << operand_b[5:0]; ok = shift_ok; end
            OP_USHR: begin v = operand_a >> operand_b[5:0]; ok = shift_ok; end
            OP_SHR:  begin
                v  = 64'($signed(operand_a) >>> operand_b[5:0]);
                ok = shift_ok;
            end
            OP_SDIV, OP_UDIV, OP_SMOD, OP_UMOD: ok = div_ok;
            OP_EQ:   begin v = {63'd0, ua == ub}; norm = 1'b0; end
            OP_NE:   begin v = {63'd0, ua != ub}; norm = 1'b0; end
            OP_LT:   begin v = {63'd0, $signed(operand_a) <  $signed(operand_b)}; norm = 1'b0; end
            OP_LE:   begin v = {63'd0, $signed(operand_a) <= $signed(operand_b)}; norm = 1'b0; end
            OP_GT:   begin v = {63'd0, $signed(operand_a) >  $signed(operand_b)}; norm = 1'b0; end
            OP_GE:   begin v = {63'd0, $signed(operand_a) >= $signed(operand_b)}; norm = 1'b0; end
            OP_ULT:  begin v = {63'd0, ua <  ub}; norm = 1'b0; end
            OP_ULE:  begin v = {63'd0, ua <= ub}; norm = 1'b0; end
            OP_UGT:  begin v = {63'd0, ua >  ub}; norm = 1'b0; end
            OP_UGE:  begin v = {63'd0, ua >= ub}; norm = 1'b0; end
            OP_ZEXT: v = operand_a & mask_of(zext_width, Dw);
            OP_CONV: v = operand_a;
            default: ok = 1'b0;
        endcase
    end

    // Next register contents, including the three 32x32 partial products.
    always_comb begin
        valid_next               = in_valid;
        cell_next.ctrl.value     = v;
        cell_next.ctrl.ok        = ok;
        cell_next.ctrl.norm      = norm;
        cell_next.ctrl.is_div    = (op inside {OP_SDIV, OP_UDIV, OP_SMOD, OP_UMOD});
        cell_next.ctrl.sel_rem   = (op == OP_SMOD) || (op == OP_UMOD);
        cell_next.ctrl.neg       = (op == OP_SDIV) ? (operand_a[63] ^ operand_b[63]) :
                                   (op == OP_SMOD) ? operand_a[63] : 1'b0;
        cell_next.ctrl.width     = type_width;
        cell_next.ctrl.uns       = type_unsigned;
        cell_next.rem            = '0;
        cell_next.dq             = sgn ? mag_a : operand_a;
        cell_next.divisor        = sgn ? mag_b : operand_b;
        is_mul_next              = (op == OP_MUL);
        pp_ll_next               = operand_a[31:0]  * operand_b[31:0];
        pp_lh_next               = operand_a[31:0]  * operand_b[63:32];
        pp_hl_next               = operand_a[63:32] * operand_b[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg   <= cell_next;
            is_mul_reg <= is_mul_next;
            pp_ll_reg  <= pp_ll_next;
            pp_lh_reg  <= pp_lh_next;
            pp_hl_reg  <= pp_hl_next;
        end
    end

    // Fold the partial products into the low 64 bits of the product.
    always_comb begin
        out_valid = valid_reg;
        out_cell  = cell_reg;
        if (is_mul_reg) begin
            out_cell.ctrl.value = pp_ll_reg + {pp_lh_reg[31:0] + pp_hl_reg[31:0], 32'd0};
        end
    end

endmodule

// ----- design/tia_div_cell.sv -----
// One cell of the divider chain: one restoring quotient bit per cell.
// Depends on tia_pkg.
module tia_div_cell (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  tia_pkg::tia_cell_t     in_cell,
    output logic                   out_valid,
    output tia_pkg::tia_cell_t     out_cell
);
    import tia_pkg::*;

    logic       valid_reg;
    tia_cell_t  cell_reg, cell_next;
    logic [64:0] trial;

    // Shift the next dividend bit into the remainder and try the subtract.
    always_comb begin
        cell_next = in_cell;
        trial     = {in_cell.rem, in_cell.dq[63]} - {1'b0, in_cell.divisor};
        if (!trial[64]) begin
            cell_next.rem = trial[63:0];
        end else begin
            cell_next.rem = {in_cell.rem[62:0], in_cell.dq[63]};
        end
        cell_next.dq = {in_cell.dq[62:0], !trial[64]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_cell  = cell_reg;

endmodule

// ----- design/tia_back.sv -----
// Output stage: picks the quotient or remainder, fixes its sign, normalizes
// the value to the result type and holds the result word. Depends on tia_pkg.
module tia_back #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  tia_pkg::tia_cell_t     in_cell,
    output logic                   out_valid,
    output logic [63:0]            result_value,
    output logic                   folded
);
    import tia_pkg::*;

    localparam logic [6:0] Dw = 7'(DATA_WIDTH);

    logic        valid_reg;
    logic [63:0] value_reg, value_next;
    logic        ok_reg;
    logic [63:0] m, v, d;
    logic [6:0]  wc;

    // Select, then mask and sign-extend.
    always_comb begin
        d  = in_cell.ctrl.sel_rem ? in_cell.rem : in_cell.dq;
        d  = in_cell.ctrl.neg ? (64'd0 - d) : d;
        v  = in_cell.ctrl.is_div ? d : in_cell.ctrl.value;
        m  = mask_of(in_cell.ctrl.width, Dw);
        wc = (in_cell.ctrl.width > Dw) ? Dw : in_cell.ctrl.width;
        if (!in_cell.ctrl.ok) begin
            value_next = '0;
        end else if (!in_cell.ctrl.norm) begin
            value_next = v;
        end else begin
            value_next = v & m;
            if (!in_cell.ctrl.uns && wc != 7'd0 && wc < 7'd64 && value_next[wc[5:0] - 6'd1]) begin
                value_next = value_next | ~m;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            value_reg <= value_next;
            ok_reg    <= in_cell.ctrl.ok;
        end
    end

    assign out_valid    = valid_reg;
    assign result_value = value_reg;
    assign folded       = ok_reg;

endmodule

// ----- design/typed_integer_alu.sv -----
// Top level of the typed integer ALU: input stage, a chain of 64 divider
// cells and the output stage. Depends on tia_pkg and the tia_* modules.
//
//  Channel | Ports            | Word contents (low bit first)
//  --------+------------------+------------------------------------------------
//  input   | s_tvalid/tready  | s_tdata: req_type[4:0], operand_a[68:5],
//          | s_tdata[151:0]   |   operand_b[132:69], type_width[139:133],
//          |                  |   type_unsigned[140], zext_width[147:141], 0s
//  result  | m_tvalid/tready  | m_tdata: result_value[63:0]; m_tuser: folded
//
// One word is accepted per cycle while the chain is not stalled; each passes
// through the input stage, 64 divider cells (one bit per cell) and the output register.
// Every word goes through the whole chain, so order is kept for all opcodes.
// A stalled result word freezes the whole chain; s_tready is low only then.
// Reset clears the valid bits of every stage.
module typed_integer_alu #(
    parameter int DATA_WIDTH = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [151:0] s_tdata,   // req_type, operand_a, operand_b, type_width,
                                    // type_unsigned, zext_width
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // result_value
    output logic [0:0]   m_tuser    // folded
);
    import tia_pkg::*;

    localparam int Cells = 64;

    logic        en;
    logic        valid_chain [Cells+1];
    tia_cell_t   cell_chain  [Cells+1];
    logic        folded;

    // The chain moves whenever the output register is empty or being taken.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    tia_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .in_valid      (s_tvalid),
        .req_type      (s_tdata[4:0]),
        .operand_a     (s_tdata[68:5]),
        .operand_b     (s_tdata[132:69]),
        .type_width    (s_tdata[139:133]),
        .type_unsigned (s_tdata[140]),
        .zext_width    (s_tdata[147:141]),
        .out_valid     (valid_chain[0]),
        .out_cell      (cell_chain[0])
    );

    // Divider chain, one quotient bit per cell.
    for (genvar i = 0; i < Cells; i++) begin : g_cell
        tia_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (valid_chain[i]),
            .in_cell   (cell_chain[i]),
            .out_valid (valid_chain[i+1]),
            .out_cell  (cell_chain[i+1])
        );
    end

    tia_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (valid_chain[Cells]),
        .in_cell      (cell_chain[Cells]),
        .out_valid    (m_tvalid),
        .result_value (m_tdata),
        .folded       (folded)
    );

    assign m_tuser = folded;

endmodule

// ----- verif/tb_top.sv -----
// Self-checking bench for typed_integer_alu: a directed table, then random words.
// Depends on tia_pkg and the design files; results are checked in order.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tia_pkg::*;

    typedef struct packed {
        logic [4:0]  opcode;
        logic [63:0] lhs;
        logic [63:0] rhs;
        logic [6:0]  width;
        logic        is_uns;
        logic [6:0]  src_width;
    } alu_req_t;

    typedef struct packed {
        logic [63:0] value;
        logic        folded;
    } alu_res_t;

    // One directed row: request, and optionally a typed-in result.
    typedef struct {
        alu_req_t req;
        bit       has_fixed;
        alu_res_t fixed;
    } dir_row_t;

    localparam logic [63:0] MinVal = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MaxVal = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] AllOnes = '1;
    localparam logic [4:0] OpBad = 5'd31;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [151:0] s_tdata;   // req_type, operand_a, operand_b, type_width,
                             // type_unsigned, zext_width
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;   // result_value
    logic [0:0]   m_tuser;   // folded

    alu_res_t pending_results[$];
    int       fail_count = 0;
    bit       drain_fast = 0;
    bit       hold_sink = 0;

    typed_integer_alu u_top (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [63:0] low_bits_mask(logic [6:0] w);
        if (w >= 7'd64) return AllOnes;
        return (64'd1 << w) - 64'd1;
    endfunction

    function automatic logic [63:0] fit_type(logic [63:0] v, logic [6:0] w, logic uns);
        logic [63:0] msk;
        logic [6:0]  cw;
        cw = (w > 7'd64) ? 7'd64 : w;
        msk = low_bits_mask(cw);
        v &= msk;
        if (!uns && cw > 0 && cw < 64 && v[cw-1]) v |= ~msk;
        return v;
    endfunction

    // Folds one request the way the block is meant to.
    function automatic alu_res_t fold_op(alu_req_t r);
        alu_res_t    res;
        logic [63:0] a, b, ua, ub, msk, v, ma, mb;
        logic        ok, norm;
        a = r.lhs;
        b = r.rhs;
        msk = low_bits_mask(r.width);
        ua = a & msk;
        ub = b & msk;
        v = 0;
        ok = 1;
        norm = 1;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        case (r.opcode)
            OP_NEG:  v = -a;
            OP_BNOT: v = ~a;
            OP_LNOT: begin v = (a == 0); norm = 0; end
            OP_ADD:  v = a + b;
            OP_SUB:  v = a - b;
            OP_MUL:  v = a * b;
            OP_AND:  v = a & b;
            OP_OR:   v = a | b;
            OP_XOR:  v = a ^ b;
            OP_SHL:  if (b < 64) v = a << b[5:0]; else ok = 0;
            OP_USHR: if (b < 64) v = a >> b[5:0]; else ok = 0;
            OP_SHR:  if (b < 64) v = $signed(a) >>> b[5:0]; else ok = 0;
            OP_SDIV, OP_SMOD: begin
                if (b == 0 || (a == MinVal && b == AllOnes)) begin
                    ok = 0;
                end else if (r.opcode == OP_SDIV) begin
                    v = ma / mb;
                    if (a[63] ^ b[63]) v = -v;
                end else begin
                    v = ma % mb;
                    if (a[63]) v = -v;
                end
            end
            OP_UDIV: if (b != 0) v = a / b; else ok = 0;
            OP_UMOD: if (b != 0) v = a % b; else ok = 0;
            OP_EQ:  begin v = (ua == ub); norm = 0; end
            OP_NE:  begin v = (ua != ub); norm = 0; end
            OP_LT:  begin v = ($signed(a) < $signed(b)); norm = 0; end
            OP_LE:  begin v = ($signed(a) <= $signed(b)); norm = 0; end
            OP_GT:  begin v = ($signed(a) > $signed(b)); norm = 0; end
            OP_GE:  begin v = ($signed(a) >= $signed(b)); norm = 0; end
            OP_ULT: begin v = (ua < ub); norm = 0; end
            OP_ULE: begin v = (ua <= ub); norm = 0; end
            OP_UGT: begin v = (ua > ub); norm = 0; end
            OP_UGE: begin v = (ua >= ub); norm = 0; end
            OP_ZEXT: v = a & low_bits_mask(r.src_width);
            OP_CONV: v = a;
            default: ok = 0;
        endcase
        if (!ok) v = 0;
        else if (norm) v = fit_type(v, r.width, r.is_uns);
        res.value = v;
        res.folded = ok;
        return res;
    endfunction

    function automatic logic [63:0] rand_operand();
        logic [63:0] v;
        case ($urandom_range(0, 7))
            0: v = MinVal;
            1: v = MaxVal;
            2: v = AllOnes;
            3: v = 64'($urandom_range(0, 3));
            4: v = 64'($signed($urandom_range(0, 200)) - 100);
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    function automatic alu_req_t rand_req();
        alu_req_t r;
        r.opcode = ($urandom_range(0, 40) == 0) ? 5'($urandom_range(28, 31))
                                                 : 5'($urandom_range(0, 27));
        r.lhs = rand_operand();
        r.rhs = rand_operand();
        if ((r.opcode inside {OP_SHL, OP_USHR, OP_SHR}) && $urandom_range(0, 4) != 0)
            r.rhs = 64'($urandom_range(0, 63));
        // Mostly legal widths; now and then anything the field holds.
        r.width = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(1, 64));
        r.is_uns = 1'($urandom_range(0, 1));
        r.src_width = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(1, 64));
        return r;
    endfunction

    // Offers one word and waits for it to be taken.
    task automatic send_word(alu_req_t r);
        int gap;
        if (!drain_fast && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {4'd0, r.src_width, r.is_uns, r.width, r.rhs, r.lhs, r.opcode};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(fold_op(r));
    endtask

    function automatic alu_req_t mk(logic [4:0] op, logic [63:0] a, logic [63:0] b,
                                    logic [6:0] w, logic u);
        alu_req_t r;
        r = '{opcode: op, lhs: a, rhs: b, width: w, is_uns: u, src_width: 7'd8};
        return r;
    endfunction

    // Result side: random stalls, one long hold-off, then free running.
    initial begin
        int stall;
        m_tready = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_sink) begin
                m_tready <= 0;
                repeat (300) @(posedge aclk);
                hold_sink = 0;
            end else if (!drain_fast && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 11);
                m_tready <= 0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1;
            @(posedge aclk);
        end
    end

    // Compare each taken result word with the oldest expectation.
    always @(posedge aclk) begin
        alu_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result value=%h folded=%b", $time, m_tdata, m_tuser);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata !== want.value) begin
                    $display("%0t: value expected %h actual %h", $time, want.value, m_tdata);
                    fail_count++;
                end
                if (m_tuser[0] !== want.folded) begin
                    $display("%0t: folded expected %b actual %b", $time, want.folded, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        dir_row_t dir_table[$];
        dir_row_t row;
        alu_req_t r;
        int wait_cycles;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed rows; fixed results only where they are obvious.
        row.has_fixed = 1;
        row.req = mk(OP_SHL, 64'd1, 64'd64, 7'd64, 1'b0); row.fixed = '{0, 0};
        dir_table.push_back(row);
        row.req = mk(OP_SDIV, 64'd5, 64'd0, 7'd64, 1'b0); row.fixed = '{0, 0};
        dir_table.push_back(row);
        row.req = mk(OP_SMOD, MinVal, AllOnes, 7'd64, 1'b0); row.fixed = '{0, 0};
        dir_table.push_back(row);
        row.req = mk(OP_UMOD, 64'd5, 64'd0, 7'd64, 1'b1); row.fixed = '{0, 0};
        dir_table.push_back(row);
        row.req = mk(OpBad, 64'd5, 64'd1, 7'd64, 1'b0); row.fixed = '{0, 0};
        dir_table.push_back(row);
        row.req = mk(OP_CONV, AllOnes, 64'd0, 7'd0, 1'b0); row.fixed = '{0, 1};
        dir_table.push_back(row);
        row.req = mk(OP_CONV, AllOnes, 64'd0, 7'd127, 1'b1); row.fixed = '{AllOnes, 1};
        dir_table.push_back(row);
        row.req = mk(OP_ADD, MaxVal, 64'd1, 7'd64, 1'b0); row.fixed = '{MinVal, 1};
        dir_table.push_back(row);
        row.has_fixed = 0;
        for (int op = 0; op <= 27; op++) begin
            row.req = mk(5'(op), (op % 2) ? MinVal : MaxVal, (op % 3) ? AllOnes : 64'd3,
                         7'((op * 5) % 64 + 1), op[0]);
            row.req.src_width = 7'(op + 20);
            dir_table.push_back(row);
        end
        row.req = mk(OP_SDIV, 64'hffff_ffff_ffff_fff9, 64'd2, 7'd64, 1'b0);
        dir_table.push_back(row);
        row.req = mk(OP_SMOD, 64'hffff_ffff_ffff_fff9, 64'd2, 7'd64, 1'b0);
        dir_table.push_back(row);

        foreach (dir_table[i]) begin
            if (dir_table[i].has_fixed) begin
                send_word(dir_table[i].req);
                void'(pending_results.pop_back());
                pending_results.push_back(dir_table[i].fixed);
            end else begin
                send_word(dir_table[i].req);
            end
        end

        // Random part; a long result stall early on fills the pipeline.
        for (int n = 0; n < 700; n++) begin
            if (n == 100) hold_sink = 1;
            if (n == 600) drain_fast = 1;
            r = rand_req();
            send_word(r);
        end
        s_tvalid <= 0;

        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 5000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (80) @(posedge aclk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
